// File: hw/rtl/sfb_pkg.sv
// Shared types, constants and the CRC byte update for the sample frame builder.
`timescale 1ns / 1ps

package sfb_pkg;

   localparam int FrameBytes   = 19;
   localparam int QueueDepth   = 2;
   localparam int CrcFirst     = 1;
   localparam int CrcLast      = 16;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'h1021;
   localparam logic [15:0] LenWord = 16'd14;

   // CSR register selects (paddr bit 2)
   localparam logic RegStartByte  = 1'b0;
   localparam logic RegSampleType = 1'b1;

   localparam logic [4:0] LastIdx  = 5'(FrameBytes - 1);
   localparam logic [4:0] CrcLoIdx = 5'(CrcLast + 1);

   typedef struct packed {
      logic [31:0] time_ms;
      logic [23:0] infrared_level;
      logic [23:0] red_level;
      logic [7:0]  heart_rate;
      logic [7:0]  saturation_pct;
   } sample_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] sample_type_code;
   } cfg_type;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ CrcPoly;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// File: hw/rtl/sfb_front.sv
// Front end: accepts samples into a two-entry queue ahead of the serializer.
`timescale 1ns / 1ps

module sfb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  sfb_pkg::sample_type sample_in,
   output logic                head_valid,
   output sfb_pkg::sample_type head,
   input  logic                head_take
);

   sfb_pkg::sample_type slot_ff [sfb_pkg::QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'(sfb_pkg::QueueDepth));
   assign head_valid = (count_ff != 2'd0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = head_take && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= sample_in;
      end
   end

endmodule

// File: hw/rtl/sfb_back.sv
// Back end: serializes one sample into frame words and appends the CRC.
`timescale 1ns / 1ps

module sfb_back (
   input  logic                clock,
   input  logic                reset,
   input  sfb_pkg::cfg_type    cfg,
   input  logic                head_valid,
   input  sfb_pkg::sample_type head,
   output logic                head_take,
   output logic                empty,
   input  logic                pop,
   output logic [7:0]          frame_byte,
   output logic                last_of_frame
);

   logic [4:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        advance, emit;
   logic [7:0]  frame [sfb_pkg::FrameBytes];
   logic [15:0] crc_seed;

   always_comb begin
      frame[0]  = cfg.start_byte;
      frame[1]  = sfb_pkg::LenWord[7:0];
      frame[2]  = sfb_pkg::LenWord[15:8];
      frame[3]  = cfg.sample_type_code;
      frame[4]  = head.time_ms[7:0];
      frame[5]  = head.time_ms[15:8];
      frame[6]  = head.time_ms[23:16];
      frame[7]  = head.time_ms[31:24];
      frame[8]  = head.infrared_level[7:0];
      frame[9]  = head.infrared_level[15:8];
      frame[10] = head.infrared_level[23:16];
      frame[11] = head.red_level[7:0];
      frame[12] = head.red_level[15:8];
      frame[13] = head.red_level[23:16];
      frame[14] = head.heart_rate;
      frame[15] = head.saturation_pct;
      frame[16] = 8'h00;
      frame[17] = crc_ff[7:0];
      frame[18] = crc_ff[15:8];
   end

   // Output register frees up when empty or being popped
   assign advance   = !out_valid_ff || pop;
   assign emit      = advance && head_valid;
   assign head_take = emit && (idx_ff == sfb_pkg::LastIdx);
   assign crc_seed  = (idx_ff == 5'(sfb_pkg::CrcFirst)) ? sfb_pkg::CrcInit : crc_ff;

   always_comb begin
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = head_valid;
      end
      if (emit) begin
         out_byte_in = frame[idx_ff];
         out_last_in = (idx_ff == sfb_pkg::LastIdx);
         idx_in      = (idx_ff == sfb_pkg::LastIdx) ? 5'd0 : idx_ff + 5'd1;
         // fold bytes one through sixteen into the CRC
         if (idx_ff >= 5'(sfb_pkg::CrcFirst) && idx_ff < sfb_pkg::CrcLoIdx) begin
            crc_in = sfb_pkg::crc_byte(crc_seed, frame[idx_ff]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff      <= crc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign empty         = !out_valid_ff;
   assign frame_byte    = out_byte_ff;
   assign last_of_frame = out_last_ff;

endmodule

// File: hw/rtl/sample_frame_builder_unit.sv
// Top level of the sample frame builder: CSRs, front queue and serializer.
`timescale 1ns / 1ps

// Each accepted sample becomes a 19-word frame on the result side: start byte,
// length 14 (LE16), type byte, 13 payload bytes (time LE32, infrared LE24,
// red LE24, heart rate, saturation, zero) and a CRC-16/CCITT-FALSE over frame
// bytes 1..16, stored low byte first; last_of_frame marks the final word. The
// serializer emits one word per cycle while pop stays high and a sample waits,
// and samples stream back to back. A two-entry queue holds accepted samples
// ahead of the serializer; the frame in flight keeps its entry until its last
// word is loaded into the output register, so full rises once a second sample
// waits behind it. Registers: start byte at 0x0 and type code at 0x4 (reset
// 0x02 and 0x01); change them only while idle.
module sample_frame_builder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_time_ms,
   input  logic [23:0] req_infrared_level,
   input  logic [23:0] req_red_level,
   input  logic [7:0]  req_heart_rate,
   input  logic [7:0]  req_saturation_pct,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_of_frame,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   sfb_pkg::cfg_type    cfg_ff, cfg_in;
   sfb_pkg::sample_type sample_in;
   sfb_pkg::sample_type head;
   logic                head_valid;
   logic                head_take;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (paddr[2])
            sfb_pkg::RegStartByte:  cfg_in.start_byte       = pwdata[7:0];
            sfb_pkg::RegSampleType: cfg_in.sample_type_code = pwdata[7:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte       <= 8'd2;
         cfg_ff.sample_type_code <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         sfb_pkg::RegStartByte:  prdata = {24'd0, cfg_ff.start_byte};
         sfb_pkg::RegSampleType: prdata = {24'd0, cfg_ff.sample_type_code};
         default:                prdata = 32'd0;
      endcase
   end

   assign sample_in = '{time_ms:        req_time_ms,
                        infrared_level: req_infrared_level,
                        red_level:      req_red_level,
                        heart_rate:     req_heart_rate,
                        saturation_pct: req_saturation_pct};

   sfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .sample_in  (sample_in),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take)
   );

   sfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_valid    (head_valid),
      .head          (head),
      .head_take     (head_take),
      .empty         (empty),
      .pop           (pop),
      .frame_byte    (rsp_frame_byte),
      .last_of_frame (rsp_last_of_frame)
   );

endmodule

// File: hw/rtl/sfb_checker.sv
// Port-level checks for the sample frame builder, bound to the top level.
`timescale 1ns / 1ps

module sfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_last_of_frame,
   input logic       pready
);

   // Nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queue not empty after reset");

   // A frame continues without a gap once its word is popped
   a_frame_contiguous: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_of_frame) |=> !empty)
      else $error("gap inside a frame");

   // A full queue always has a frame in flight, so a word is waiting
   a_full_needs_work: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("queue filled with idle serializer");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_frame_byte)
                            && $stable(rsp_last_of_frame)))
      else $error("stalled word changed");

   a_pready_high: assert property (@(posedge clock) pready)
      else $error("pready dropped");

endmodule

bind sample_frame_builder_unit sfb_checker u_sfb_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .empty             (empty),
   .pop               (pop),
   .rsp_frame_byte    (rsp_frame_byte),
   .rsp_last_of_frame (rsp_last_of_frame),
   .pready            (pready)
);
